// ----- rtl/mfe_pkg.sv -----
package mfe_pkg;

	localparam int unsigned MAX_IN_BYTES_DEF  = 16;
	localparam int unsigned MAX_OUT_BYTES_DEF = 16;
	localparam int unsigned HEADER_BYTES      = 2;

	// Request codes.
	localparam logic [2:0] REQ_LINE    = 3'd0;
	localparam logic [2:0] REQ_WR_OUT  = 3'd1;
	localparam logic [2:0] REQ_BIT_OUT = 3'd2;
	localparam logic [2:0] REQ_RD_IN   = 3'd3;
	localparam logic [2:0] REQ_RD_OUT  = 3'd4;
	localparam logic [2:0] REQ_FLAGS   = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_HOST  = 2'd1;
	localparam logic [1:0] KIND_FLAGS = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_UNIT  = 3'd0;
	localparam logic [2:0] REG_START = 3'd1;
	localparam logic [2:0] REG_INLEN = 3'd2;
	localparam logic [2:0] REG_OUTLEN = 3'd3;
	localparam logic [2:0] REG_CHECK = 3'd4;

	typedef struct packed {
		logic [6:0] unit_address;
		logic [7:0] start_marker;
		logic [4:0] in_length;
		logic [4:0] out_length;
		logic       check_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] line_byte;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic [2:0] bit_index;
		logic       bit_value;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] data_byte;
		logic       last_of_run;
		logic       new_data_flag;
		logic       reply_sent_flag;
	} rsp_t;

	typedef enum logic [2:0] {
		LOP_NONE,
		LOP_START,
		LOP_ADDR,
		LOP_PAYLOAD,
		LOP_TAIL
	} line_op_t;

	typedef struct packed {
		logic     acc;
		line_op_t line_op;
		logic     recv_init;
		logic     enter_chk;
		logic     tail_rd;
		logic     commit;
		logic     reply_go;
		logic     strm_load;
	} cmd_t;

	typedef struct packed {
		logic start_hit;
		logic addr_match;
		logic addr_rd;
		logic recv_done;
		logic tail_last;
		logic tail_good;
		logic out_free;
		logic strm_last;
		logic chk;
	} sts_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = v[7-i];
		return r;
	endfunction

	// Length register with zero acting as one and saturation at the maximum.
	function automatic logic [7:0] eff_len(input logic [4:0] v, input int unsigned mx);
		logic [7:0] r;
		if (v == 5'd0) r = 8'd1;
		else if (32'(v) > mx) r = 8'(mx);
		else r = 8'(v);
		return r;
	endfunction

endpackage

// ----- rtl/mfe_if.sv -----
interface mfe_in_if;
	import mfe_pkg::*;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] line_byte;
	logic [3:0] byte_index;
	logic [7:0] byte_value;
	logic [2:0] bit_index;
	logic       bit_value;
	modport source(output valid, req_type, line_byte, byte_index, byte_value, bit_index,
		bit_value, input ready);
	modport sink(input valid, req_type, line_byte, byte_index, byte_value, bit_index,
		bit_value, output ready);
endinterface

interface mfe_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] data_byte;
	logic       last_of_run;
	logic       new_data_flag;
	logic       reply_sent_flag;
	modport source(output valid, result_kind, data_byte, last_of_run, new_data_flag,
		reply_sent_flag, input ready);
	modport sink(input valid, result_kind, data_byte, last_of_run, new_data_flag,
		reply_sent_flag, output ready);
endinterface

// ----- rtl/multidrop_slave_frame_engine_top.sv -----
// A host read or flag read gives its item in the cycle after it is accepted.
// A reply's first byte is loaded into the output register once the controller has entered
// its stream mode after the last request byte is accepted, and the reply then streams one
// item per cycle while the result side does not stall. One input item is taken per cycle
// while no reply is streaming and the result side is free; the input is held while the
// payload bytes and tail bytes of a reply stream out, and longer while the result side stalls.
// Reset (arst_n, asynchronous, low) clears phase, counters, flags and data bytes;
// registers return to address 0, marker 0, lengths 1 and checking on.
module multidrop_slave_frame_engine_top import mfe_pkg::*; #(
	parameter int unsigned MAX_IN_BYTES  = MAX_IN_BYTES_DEF,
	parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mfe_in_if.sink      rq,
	mfe_out_if.source   rs
);
	// The register block holds the five configuration registers.
	cfg_t cfg;
	req_t req;
	rsp_t rsp;
	cmd_t cmd;
	sts_t sts;
	logic rdy;
	logic ov;

	mfe_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	// Gather the input item into one word for the datapath.
	assign req.req_type   = rq.req_type;
	assign req.line_byte  = rq.line_byte;
	assign req.byte_index = rq.byte_index;
	assign req.byte_value = rq.byte_value;
	assign req.bit_index  = rq.bit_index;
	assign req.bit_value  = rq.bit_value;

	// The controller tracks the frame phase and the reply stream and decides
	// when an item is taken; the datapath holds the buffers and the output register.
	mfe_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (rq.valid),
		.req_type (rq.req_type),
		.sts,
		.in_ready (rdy),
		.cmd
	);

	mfe_dp #(
		.MAX_IN_BYTES  (MAX_IN_BYTES),
		.MAX_OUT_BYTES (MAX_OUT_BYTES)
	) u_dp (
		.clk, .arst_n, .cfg, .req, .cmd,
		.out_ready (rs.ready),
		.sts,
		.out_valid (ov),
		.rsp
	);

	assign rq.ready           = rdy;
	assign rs.valid           = ov;
	assign rs.result_kind     = rsp.result_kind;
	assign rs.data_byte       = rsp.data_byte;
	assign rs.last_of_run     = rsp.last_of_run;
	assign rs.new_data_flag   = rsp.new_data_flag;
	assign rs.reply_sent_flag = rsp.reply_sent_flag;
endmodule

// ----- rtl/mfe_cfg.sv -----
module mfe_cfg import mfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_address <= 7'd0;
			cfg_q.start_marker <= 8'd0;
			cfg_q.in_length    <= 5'd1;
			cfg_q.out_length   <= 5'd1;
			cfg_q.check_enable <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_UNIT:   cfg_q.unit_address <= pwdata[6:0];
				REG_START:  cfg_q.start_marker <= pwdata[7:0];
				REG_INLEN:  cfg_q.in_length    <= pwdata[4:0];
				REG_OUTLEN: cfg_q.out_length   <= pwdata[4:0];
				REG_CHECK:  cfg_q.check_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_UNIT:   prdata = {25'd0, cfg_q.unit_address};
			REG_START:  prdata = {24'd0, cfg_q.start_marker};
			REG_INLEN:  prdata = {27'd0, cfg_q.in_length};
			REG_OUTLEN: prdata = {27'd0, cfg_q.out_length};
			REG_CHECK:  prdata = {31'd0, cfg_q.check_enable};
			default:    prdata = 32'd0;
		endcase
	end
endmodule

// ----- rtl/mfe_ctrl.sv -----
module mfe_ctrl import mfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] req_type,
	input  sts_t       sts,
	output logic       in_ready,
	output cmd_t       cmd
);
	typedef enum logic [4:0] {
		PH_WAIT = 5'b00001,
		PH_ADDR = 5'b00010,
		PH_RECV = 5'b00100,
		PH_CHKW = 5'b01000,
		PH_CHKR = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		M_IDLE   = 2'b01,
		M_STREAM = 2'b10
	} mode_t;

	phase_t phase_q, phase_d;
	mode_t  mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			mode_q  <= M_IDLE;
		end else begin
			phase_q <= phase_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		cmd      = '0;
		phase_d  = phase_q;
		mode_d   = mode_q;
		in_ready = (mode_q == M_IDLE) && sts.out_free;
		cmd.acc  = in_valid && in_ready;
		cmd.tail_rd = (phase_q == PH_CHKR);
		if (mode_q == M_STREAM) begin
			cmd.strm_load = sts.out_free;
			if (sts.out_free && sts.strm_last) mode_d = M_IDLE;
		end
		if (cmd.acc && req_type == REQ_LINE) begin
			case (phase_q)
				PH_ADDR: begin
					cmd.line_op = LOP_ADDR;
					phase_d = PH_WAIT;
					if (sts.addr_match) begin
						if (!sts.addr_rd) begin
							phase_d = PH_RECV;
							cmd.recv_init = 1'b1;
						end else if (sts.chk) begin
							phase_d = PH_CHKR;
							cmd.enter_chk = 1'b1;
						end else begin
							cmd.reply_go = 1'b1;
							mode_d = M_STREAM;
						end
					end
				end
				PH_RECV: begin
					cmd.line_op = LOP_PAYLOAD;
					if (sts.recv_done) begin
						if (sts.chk) begin
							phase_d = PH_CHKW;
							cmd.enter_chk = 1'b1;
						end else begin
							cmd.commit = 1'b1;
							phase_d = PH_WAIT;
						end
					end
				end
				PH_CHKW, PH_CHKR: begin
					cmd.line_op = LOP_TAIL;
					if (sts.tail_last) begin
						phase_d = PH_WAIT;
						if (sts.tail_good) begin
							if (phase_q == PH_CHKW) begin
								cmd.commit = 1'b1;
							end else begin
								cmd.reply_go = 1'b1;
								mode_d = M_STREAM;
							end
						end
					end
				end
				default: begin
					phase_d = PH_WAIT;
					if (sts.start_hit) begin
						cmd.line_op = LOP_START;
						phase_d = PH_ADDR;
					end
				end
			endcase
		end
	end

	a_no_acc_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_STREAM) |-> !cmd.acc)
		else $error("item accepted during reply stream");
	a_go_streams: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reply_go |=> (mode_q == M_STREAM))
		else $error("reply did not start");
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.strm_load && sts.strm_last) |=> (mode_q == M_IDLE))
		else $error("stream did not end after last byte");
endmodule

// ----- rtl/mfe_dp.sv -----
module mfe_dp import mfe_pkg::*; #(
	parameter int unsigned MAX_IN_BYTES  = MAX_IN_BYTES_DEF,
	parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  req_t req,
	input  cmd_t cmd,
	input  logic out_ready,
	output sts_t sts,
	output logic out_valid,
	output rsp_t rsp
);
	localparam int unsigned CW    = $clog2(MAX_IN_BYTES + 1);
	localparam int unsigned IWI   = (MAX_IN_BYTES > 1) ? $clog2(MAX_IN_BYTES) : 1;
	localparam int unsigned IWO   = (MAX_OUT_BYTES > 1) ? $clog2(MAX_OUT_BYTES) : 1;
	localparam int unsigned FRAME = MAX_IN_BYTES + HEADER_BYTES;
	localparam int unsigned FNB   = (FRAME + 7) / 8;
	localparam int unsigned TDEP  = 1 + FNB;
	localparam int unsigned TW    = $clog2(TDEP + 1);
	localparam int unsigned NW    = $clog2(FRAME + 1);
	localparam int unsigned ONB   = (MAX_OUT_BYTES + 7) / 8;
	localparam int unsigned OTOT  = MAX_OUT_BYTES + 1 + ONB;
	localparam int unsigned SW    = $clog2(OTOT + 1);

	logic [7:0]       fb_q [MAX_IN_BYTES];
	logic [7:0]       ib_q [MAX_IN_BYTES];
	logic [7:0]       ob_q [MAX_OUT_BYTES];
	logic [FRAME-1:0] fpar_q;
	logic [7:0]       fxor_q;
	logic [CW-1:0]    cnt_q;
	logic [TW-1:0]    tcnt_q;
	logic             ok_q;
	logic             fresh_q, reply_q;
	logic [SW-1:0]    sn_q, stot_q, k_q;
	logic [7:0]       oxor_q;
	logic [MAX_OUT_BYTES-1:0] opar_q;
	logic             ov_q;
	rsp_t             rsp_q;

	logic [7:0]       b;
	logic [CW-1:0]    inl;
	logic [SW-1:0]    outl;
	logic [7:0]       idx8;
	logic [IWI-1:0]   idxi;
	logic [IWO-1:0]   ra;
	logic [7:0]       ob_rd;
	logic             store_now;
	logic [CW-1:0]    cnt_next, cnt_eff;
	logic [NW-1:0]    nfr;
	logic [TW-1:0]    need, tnext;
	logic [7:0]       texp;
	logic [8*FNB-1:0] fpad;
	logic [8*ONB-1:0] opad;
	logic [TW-1:0]    tj;
	logic [SW-1:0]    sj;
	logic [7:0]       sbyte;
	logic             out_free, host_ld;
	logic             in_range_i, in_range_o;

	assign b     = req.line_byte;
	assign inl   = CW'(eff_len(cfg.in_length, MAX_IN_BYTES));
	assign outl  = SW'(eff_len(cfg.out_length, MAX_OUT_BYTES));
	assign idx8  = {4'd0, req.byte_index};
	assign idxi  = idx8[IWI-1:0];
	assign in_range_i = 8'(inl) > idx8;
	assign in_range_o = 8'(outl) > idx8;
	assign ra    = cmd.acc ? idx8[IWO-1:0] : k_q[IWO-1:0];
	assign ob_rd = ob_q[ra];

	// Payload store and count.
	assign store_now = (cmd.line_op == LOP_PAYLOAD) && (cnt_q < inl);
	assign cnt_next  = store_now ? cnt_q + CW'(1) : cnt_q;
	assign cnt_eff   = (cmd.line_op == LOP_PAYLOAD) ? cnt_next : cnt_q;

	// Expected tail byte, built from the running XOR and parity bits.
	assign nfr   = cmd.tail_rd ? NW'(HEADER_BYTES) : NW'(HEADER_BYTES) + NW'(cnt_q);
	assign need  = TW'(1 + ((32'(nfr) + 7) >> 3));
	assign tnext = tcnt_q + TW'(1);
	assign fpad  = (8*FNB)'(fpar_q);
	assign tj    = tcnt_q - TW'(1);
	assign texp  = (tcnt_q == '0) ? fxor_q : rev8(fpad[8*tj +: 8]);

	// Reply stream byte.
	assign opad  = (8*ONB)'(opar_q);
	assign sj    = k_q - sn_q - SW'(1);
	always_comb begin
		if (k_q < sn_q) sbyte = ob_rd;
		else if (k_q == sn_q) sbyte = oxor_q;
		else sbyte = rev8(opad[8*sj +: 8]);
	end

	assign out_free = !ov_q || out_ready;
	assign host_ld  = cmd.acc && (req.req_type == REQ_RD_IN || req.req_type == REQ_RD_OUT ||
		req.req_type == REQ_FLAGS);

	always_comb begin
		sts.start_hit  = (b == cfg.start_marker);
		sts.addr_match = (b[7:1] == cfg.unit_address);
		sts.addr_rd    = b[0];
		sts.recv_done  = (cnt_next >= inl);
		sts.tail_last  = (tnext >= need);
		sts.tail_good  = ok_q && (b == texp);
		sts.out_free   = out_free;
		sts.strm_last  = (k_q == stot_q - SW'(1));
		sts.chk        = cfg.check_enable;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			tcnt_q  <= '0;
			ok_q    <= 1'b0;
			fresh_q <= 1'b0;
			reply_q <= 1'b0;
			ov_q    <= 1'b0;
			k_q     <= '0;
			sn_q    <= '0;
			stot_q  <= '0;
			for (int i = 0; i < MAX_IN_BYTES; i++) ib_q[i] <= 8'd0;
			for (int i = 0; i < MAX_OUT_BYTES; i++) ob_q[i] <= 8'd0;
		end else begin
			if (cmd.recv_init) cnt_q <= '0;
			else if (cmd.line_op == LOP_PAYLOAD) cnt_q <= cnt_next;
			if (cmd.enter_chk) begin
				tcnt_q <= '0;
				ok_q   <= 1'b1;
			end else if (cmd.line_op == LOP_TAIL) begin
				tcnt_q <= tnext;
				ok_q   <= ok_q && (b == texp);
			end
			if (cmd.commit) begin
				fresh_q <= 1'b1;
				for (int i = 0; i < MAX_IN_BYTES; i++) begin
					if (CW'(i) < cnt_eff)
						ib_q[i] <= (store_now && cnt_q == CW'(i)) ? b : fb_q[i];
				end
			end
			if (cmd.acc && in_range_o) begin
				if (req.req_type == REQ_WR_OUT) ob_q[idx8[IWO-1:0]] <= req.byte_value;
				else if (req.req_type == REQ_BIT_OUT)
					ob_q[idx8[IWO-1:0]][req.bit_index] <= req.bit_value;
			end
			if (cmd.acc && req.req_type == REQ_FLAGS) begin
				fresh_q <= 1'b0;
				reply_q <= 1'b0;
			end
			if (cmd.reply_go) begin
				reply_q <= 1'b1;
				k_q     <= '0;
				sn_q    <= outl;
				stot_q  <= cfg.check_enable ?
					outl + SW'(1) + SW'((32'(outl) + 7) >> 3) : outl;
			end else if (cmd.strm_load) begin
				k_q <= k_q + SW'(1);
			end
			if (cmd.strm_load || host_ld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// Payload, check and output registers.
	always_ff @(posedge clk) begin
		if (store_now) fb_q[cnt_q[IWI-1:0]] <= b;
		case (cmd.line_op)
			LOP_START: begin
				fxor_q <= b;
				fpar_q <= {{(FRAME-1){1'b0}}, ^b};
			end
			LOP_ADDR: begin
				fxor_q    <= fxor_q ^ b;
				fpar_q[1] <= ^b;
			end
			LOP_PAYLOAD: begin
				if (store_now) begin
					fxor_q <= fxor_q ^ b;
					for (int i = 0; i < MAX_IN_BYTES; i++)
						if (cnt_q == CW'(i)) fpar_q[HEADER_BYTES+i] <= ^b;
				end
			end
			default: ;
		endcase
		if (cmd.reply_go) begin
			oxor_q <= 8'd0;
			opar_q <= '0;
		end else if (cmd.strm_load && k_q < sn_q) begin
			oxor_q <= oxor_q ^ ob_rd;
			for (int i = 0; i < MAX_OUT_BYTES; i++)
				if (k_q == SW'(i)) opar_q[i] <= ^ob_rd;
		end
		if (cmd.strm_load) begin
			rsp_q.result_kind     <= KIND_TX;
			rsp_q.data_byte       <= sbyte;
			rsp_q.last_of_run     <= sts.strm_last;
			rsp_q.new_data_flag   <= fresh_q;
			rsp_q.reply_sent_flag <= reply_q;
		end else if (host_ld) begin
			rsp_q.last_of_run     <= 1'b1;
			rsp_q.new_data_flag   <= fresh_q;
			rsp_q.reply_sent_flag <= reply_q;
			case (req.req_type)
				REQ_RD_IN: begin
					rsp_q.result_kind <= KIND_HOST;
					rsp_q.data_byte   <= in_range_i ? ib_q[idxi] : 8'd0;
				end
				REQ_RD_OUT: begin
					rsp_q.result_kind <= KIND_HOST;
					rsp_q.data_byte   <= in_range_o ? ob_rd : 8'd0;
				end
				default: begin
					rsp_q.result_kind <= KIND_FLAGS;
					rsp_q.data_byte   <= 8'd0;
				end
			endcase
		end
	end

	assign out_valid = ov_q;
	assign rsp       = rsp_q;
endmodule
